// ===== sv/rag_pkg.sv =====
`timescale 1ns / 1ps
package rag_pkg;

   localparam logic [31:0] ACL_MAGIC       = 32'h4353_4543;
   localparam logic [15:0] ACL_VERSION     = 16'd1;
   localparam logic [15:0] ACL_KIND_ACCESS = 16'd1;

   localparam logic CMD_DEFINE = 1'b0;
   localparam logic CMD_ACCESS = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_REQ   = 3'd1;
   localparam logic [2:0] ST_NOT_READY = 3'd2;
   localparam logic [2:0] ST_NO_REGION = 3'd3;
   localparam logic [2:0] ST_LIST_FULL = 3'd4;

   localparam logic CSR_TABLE_READY  = 1'b0;
   localparam logic CSR_SEARCH_LIMIT = 1'b1;

   typedef struct packed {
      logic define;
      logic grant;
      logic compare;
   } rag_ctl_type;

endpackage

// ===== sv/rag_cell.sv =====
`timescale 1ns / 1ps
module rag_cell
   import rag_pkg::*;
#(
   parameter int CW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  rag_ctl_type   ctl,
   input  logic          slot_sel,
   input  logic          enable,
   input  logic [63:0]   slot_start,
   input  logic [63:0]   slot_end,
   input  logic [63:0]   acc_off,
   input  logic [63:0]   acc_end,
   input  logic          hit_in,
   output logic          hit_out,
   output logic          sel,
   output logic [CW-1:0] count
);

   logic [63:0]   start_ff;
   logic [63:0]   end_ff;
   logic          hit_ff;
   logic          hit_in_c;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   always_comb begin
      hit_in_c = hit_ff;
      if (ctl.compare) begin
         hit_in_c = enable && (acc_off >= start_ff) && (acc_end <= end_ff);
      end
      count_in = count_ff;
      if (ctl.define && slot_sel) begin
         count_in = '0;
      end else if (ctl.grant && sel) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         hit_ff   <= hit_in_c;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.define && slot_sel) begin
         start_ff <= slot_start;
         end_ff   <= slot_end;
      end
   end

   assign hit_out = hit_in | hit_ff;
   assign sel     = hit_ff & ~hit_in;
   assign count   = count_ff;

endmodule

// ===== sv/region_acl_grant_top.sv =====
`timescale 1ns / 1ps
// Region access-control table with a per-region list of granted principals.
// Requests arrive on the req_ channel (valid/ready); each request yields
// exactly one response on the rsp_ channel (valid/ready). A define-region
// request writes a slot's bounds and empties its list; an access request is
// checked, matched against the regions and its principal appended unless it
// is already listed or the list is full. The csr_ port writes the ready flag
// (index 0) and the number of regions searched (index 1); the user must write
// it only while the block is idle; the block itself leaves that unchecked.
// An access request passes through the match and select states, and the list
// scan state if a region matches, before its response is registered; any
// define-region or rejected request goes straight to the response. The list
// memory is read one entry per cycle through a registered read. One request
// is in flight at a time. The response sits in an output register, so a new
// request is accepted while the previous response waits; if the receiver
// stalls, the block holds the next finished response until the register
// frees. Reset clears the control state, the ready flag, the search limit,
// the response valid flag and all list counts; region bounds and list
// entries hold nothing until written.
module region_acl_grant_top
   import rag_pkg::*;
#(
   parameter int NUM_REGIONS       = 16,
   parameter int GRANTS_PER_REGION = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_request_magic,
   input  logic [15:0] req_request_version,
   input  logic [15:0] req_request_kind,
   input  logic [63:0] req_principal_id,
   input  logic [63:0] req_access_offset,
   input  logic [31:0] req_access_length,
   input  logic [3:0]  req_slot_index,
   input  logic [63:0] req_slot_start,
   input  logic [63:0] req_slot_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_matched_region,
   output logic        rsp_already_granted
);

   localparam int RW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
   localparam int CW    = $clog2(GRANTS_PER_REGION + 1);
   localparam int DEPTH = NUM_REGIONS * GRANTS_PER_REGION;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MATCH = 5'b00010,
      S_SEL   = 5'b00100,
      S_SCAN  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic        ready_ff, ready_in;
   logic [4:0]  count_ff, count_in;
   logic [63:0] who_ff, who_in;
   logic [63:0] off_ff, off_in;
   logic [63:0] end_ff, end_in;
   logic        rng_ff, rng_in;
   logic [2:0]  stat_ff, stat_in;
   logic        alr_ff, alr_in;
   logic [RW-1:0] r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic        rdv_ff, rdv_in;
   logic [63:0] rd_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_stat_ff, rsp_stat_in;
   logic [3:0]  rsp_reg_ff, rsp_reg_in;
   logic        rsp_alr_ff, rsp_alr_in;
   logic [63:0] grant_mem_ff [DEPTH];

   rag_ctl_type   ctl;
   logic          mem_we;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [64:0]   sum;
   logic          bad;
   logic [NUM_REGIONS:0]   chain;
   logic [NUM_REGIONS-1:0] sel;
   logic [CW-1:0] cnt_arr [NUM_REGIONS];
   logic [RW-1:0] enc;
   logic [CW-1:0] cmux;

   for (genvar i = 0; i < NUM_REGIONS; i++) begin : g_cell
      rag_cell #(.CW(CW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .slot_sel   (int'(req_slot_index) == i),
         .enable     (rng_ff && (int'(count_ff) > i)),
         .slot_start (req_slot_start),
         .slot_end   (req_slot_end),
         .acc_off    (off_ff),
         .acc_end    (end_ff),
         .hit_in     (chain[i]),
         .hit_out    (chain[i+1]),
         .sel        (sel[i]),
         .count      (cnt_arr[i])
      );
   end
   assign chain[0] = 1'b0;

   always_comb begin
      enc  = '0;
      cmux = '0;
      for (int i = 0; i < NUM_REGIONS; i++) begin
         if (sel[i]) begin
            enc  = enc | RW'(i);
            cmux = cmux | cnt_arr[i];
         end
      end
   end

   assign sum     = {1'b0, req_access_offset} + {33'd0, req_access_length};
   assign bad     = (req_request_magic != ACL_MAGIC) || (req_request_version != ACL_VERSION)
                    || (req_request_kind != ACL_KIND_ACCESS);
   assign req_ready = (state_ff == S_IDLE);
   assign rd_en   = (state_ff == S_SCAN) && (iss_ff < cnt_ff);
   assign rd_addr = AW'(int'(r_ff) * GRANTS_PER_REGION + int'(iss_ff));
   assign wr_addr = AW'(int'(r_ff) * GRANTS_PER_REGION + int'(cnt_ff));

   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      count_in     = count_ff;
      who_in       = who_ff;
      off_in       = off_ff;
      end_in       = end_ff;
      rng_in       = rng_ff;
      stat_in      = stat_ff;
      alr_in       = alr_ff;
      r_in         = r_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      rdv_in       = rdv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_reg_in   = rsp_reg_ff;
      rsp_alr_in   = rsp_alr_ff;
      ctl          = '0;
      mem_we       = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_READY:  ready_in = csr_wdata[0];
            CSR_SEARCH_LIMIT: count_in = csr_wdata;
            default: ;
         endcase
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               alr_in   = 1'b0;
               r_in     = '0;
               who_in   = req_principal_id;
               off_in   = req_access_offset;
               end_in   = sum[63:0];
               rng_in   = (req_access_length != 32'd0) && !sum[64];
               state_in = S_DONE;
               if (req_command == CMD_DEFINE) begin
                  ctl.define = 1'b1;
                  stat_in    = ST_OK;
               end else if (bad) begin
                  stat_in = ST_BAD_REQ;
               end else if (!ready_ff) begin
                  stat_in = ST_NOT_READY;
               end else begin
                  state_in = S_MATCH;
               end
            end
         end
         S_MATCH: begin
            ctl.compare = 1'b1;
            state_in    = S_SEL;
         end
         S_SEL: begin
            if (!chain[NUM_REGIONS]) begin
               stat_in  = ST_NO_REGION;
               state_in = S_DONE;
            end else begin
               r_in     = enc;
               cnt_in   = cmux;
               iss_in   = '0;
               rdv_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rdv_in = rd_en;
            if (rd_en) begin
               iss_in = iss_ff + CW'(1);
            end
            if (rdv_ff && (rd_data_ff == who_ff)) begin
               alr_in   = 1'b1;
               stat_in  = ST_OK;
               state_in = S_DONE;
            end else if ((iss_ff == cnt_ff) && !rdv_ff) begin
               if (int'(cnt_ff) >= GRANTS_PER_REGION) begin
                  stat_in = ST_LIST_FULL;
               end else begin
                  stat_in   = ST_OK;
                  mem_we    = 1'b1;
                  ctl.grant = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_reg_in   = 4'(r_ff);
               rsp_alr_in   = alr_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         count_ff     <= count_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      who_ff      <= who_in;
      off_ff      <= off_in;
      end_ff      <= end_in;
      rng_ff      <= rng_in;
      stat_ff     <= stat_in;
      alr_ff      <= alr_in;
      r_ff        <= r_in;
      cnt_ff      <= cnt_in;
      iss_ff      <= iss_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_reg_ff  <= rsp_reg_in;
      rsp_alr_ff  <= rsp_alr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grant_mem_ff[wr_addr] <= who_ff;
      end
      if (rd_en) begin
         rd_data_ff <= grant_mem_ff[rd_addr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_stat_ff;
   assign rsp_matched_region  = rsp_reg_ff;
   assign rsp_already_granted = rsp_alr_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");
   a_already_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_already_granted |-> rsp_status == ST_OK)
      else $error("already granted with error status");
   a_region_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BAD_REQ || rsp_status == ST_NOT_READY
      || rsp_status == ST_NO_REGION) |-> rsp_matched_region == 4'd0)
      else $error("matched region set on error");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> iss_ff <= cnt_ff)
      else $error("list scan past count");
`endif

endmodule
